// ===== sv/sptc_pkg.sv =====
// shared types and constants of the steering torque controller
package sptc_pkg;

    // fixed point and iteration counts
    localparam int FRAC_BITS  = 16;
    localparam int ERR_SHIFT  = FRAC_BITS - 4;
    localparam int MUL_W      = 24;
    localparam int DIV_W      = 64;
    localparam int DVS_W      = 26;
    localparam int SQRT_STEPS = 32;
    localparam int CNT_W      = 7;

    localparam logic [CNT_W-1:0] MUL_STEPS  = CNT_W'(MUL_W);
    localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(DIV_W);
    localparam logic [CNT_W-1:0] ROOT_STEPS = CNT_W'(SQRT_STEPS);

    // integrator range
    localparam logic signed [47:0] INT_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] INT_MIN = 48'sh8000_0000_0000;

    // torque percentages in fixed point
    localparam logic signed [33:0] TOR50 = 34'(50 << FRAC_BITS);
    localparam logic signed [33:0] TOR58 = 34'(58 << FRAC_BITS);
    localparam logic [DVS_W-1:0]   FRAC_DEN = DVS_W'(100 << FRAC_BITS);
    localparam logic [MUL_W-1:0]   PCT_SCALE = MUL_W'(10000);

    // per speed band map coefficients, scaled by 1e4
    localparam logic signed [63:0] LIN_A_SH [4] = '{
        64'sd32962000 <<< FRAC_BITS, 64'sd21206000 <<< FRAC_BITS,
        64'sd18169000 <<< FRAC_BITS, 64'sd14562000 <<< FRAC_BITS};
    localparam logic [DVS_W-1:0] LIN_B [4] = '{
        DVS_W'(659250), DVS_W'(424125), DVS_W'(363375), DVS_W'(291250)};
    localparam logic [MUL_W-1:0] QUAD_A4 [4] = '{
        MUL_W'(6132152), MUL_W'(5146532), MUL_W'(3033776), MUL_W'(2374628)};
    localparam logic [DVS_W-1:0] QUAD_A2 [4] = '{
        DVS_W'(3066076), DVS_W'(2573266), DVS_W'(1516888), DVS_W'(1187314)};
    localparam logic signed [63:0] QUAD_NB [4] = '{
        64'sd168217170, 64'sd145557517, 64'sd85858332, 64'sd68027173};
    localparam logic signed [63:0] QUAD_BB [4] = '{
        64'sd168217170 * 64'sd168217170, 64'sd145557517 * 64'sd145557517,
        64'sd85858332 * 64'sd85858332, 64'sd68027173 * 64'sd68027173};
    localparam logic signed [63:0] QUAD_C [4] = '{
        64'sd4604729340, 64'sd4117496327, 64'sd2431283957, 64'sd1950844799};

    // register indexes
    typedef enum logic [2:0] {
        CFG_KP_GAIN,
        CFG_KI_GAIN,
        CFG_OUTPUT_LIMIT,
        CFG_SAMPLE_RATE,
        CFG_MAX_TORQUE,
        CFG_DEADBAND
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE, S_INT_DIV, S_KP_MUL, S_KI_MUL, S_CLAMP, S_DIFF,
        S_DEN_MUL, S_AW_DIV, S_LIN_MUL, S_LIN_PREP, S_LIN_DIV,
        S_QUAD_PREP, S_DISC_MUL, S_SQRT, S_SOL_DIV, S_LIMIT, S_MIRROR,
        S_ADJ_MUL, S_ADJ_DIV, S_RES, S_FRAC_DIV, S_OUT
    } t_state;

    // saturate to the integrator range
    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        if (v > 50'(INT_MAX)) begin
            return INT_MAX;
        end else if (v < 50'(INT_MIN)) begin
            return INT_MIN;
        end
        return v[47:0];
    endfunction

endpackage

// ===== sv/steering_pi_torque_controller.sv =====
// steering PI torque controller: bit-serial sequencer with shared mul, div and root units
// every item runs the linear map, plus anti-windup when it is active (ki nonzero)
//   and the quadratic map when that is taken
// each multiply works one multiplier bit per cycle, each divide one quotient bit
//   per cycle, the root one root bit per cycle
// throughput: one item at a time; the next beat is taken once the result sits in the
//   output register; reset clears the registers to defaults, integrator and last error
module steering_pi_torque_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [14:0] i_target_angle,
    input  logic signed [14:0] i_measured_angle,
    input  logic signed [11:0] i_vehicle_speed,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_torque_command,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    // control state
    sptc_pkg::t_state            r_state, n_state;
    logic                        r_run;
    logic [sptc_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_out_valid;
    logic [15:0]                 r_kp, r_ki, r_lim;
    logic [9:0]                  r_rate;
    logic [6:0]                  r_max_pct;
    logic [5:0]                  r_dead_pct;
    logic signed [47:0]          r_integ;
    logic [14:0]                 r_prev;

    // item datapath
    logic [14:0]                 r_err;
    logic                        r_neg;
    logic [1:0]                  r_sel;
    logic signed [63:0]          r_uu, r_u10k, r_work;
    logic signed [33:0]          r_u, r_tor;
    logic                        r_dneg, r_clip;
    logic [63:0]                 r_mag;
    logic [sptc_pkg::DVS_W-1:0]  r_den;
    logic [22:0]                 r_ax, r_adj;
    logic                        r_xneg, r_xzero;
    logic signed [26:0]          r_res;
    logic [15:0]                 r_frac, r_out;

    // serial units
    logic signed [63:0]          r_mcand, r_prod;
    logic [sptc_pkg::MUL_W-1:0]  r_mplier;
    logic [sptc_pkg::DIV_W-1:0]  r_dvd;
    logic [sptc_pkg::DVS_W-1:0]  r_dvs, r_rem;
    logic [63:0]                 r_sq_x;
    logic [33:0]                 r_sq_rem;
    logic [31:0]                 r_sq_root;

    // operand selection and helpers
    logic                        st_mul, st_div, st_sqrt, st_op, op_done, out_free;
    logic [sptc_pkg::CNT_W-1:0]  op_steps;
    logic signed [63:0]          mul_mcand;
    logic [sptc_pkg::MUL_W-1:0]  mul_mplier;
    logic [sptc_pkg::DIV_W-1:0]  div_dvd;
    logic [sptc_pkg::DVS_W-1:0]  div_dvs;
    logic signed [15:0]          in_diff;
    logic [9:0]                  rate_eff;
    logic signed [33:0]          lim_q;
    logic signed [63:0]          lin_q, disc;
    logic [6:0]                  max_c, min_c;
    logic [5:0]                  m_pct, band;
    logic signed [6:0]           w_pct;
    logic [5:0]                  w_abs;
    logic signed [33:0]          max_q, min_q, x_a, x_b;
    logic signed [26:0]          off;
    logic [sptc_pkg::DVS_W:0]    rem_sh;
    logic                        rem_ge;
    logic [35:0]                 sq_sh, sq_trial;
    logic                        sq_ge;
    logic [48:0]                 q_sat;
    logic [15:0]                 err_sum;

    // derived operands
    assign in_diff  = 16'(i_target_angle) - 16'(i_measured_angle);
    assign rate_eff = (r_rate == '0) ? 10'd1 : r_rate;
    assign lim_q    = 34'({r_lim, {sptc_pkg::FRAC_BITS{1'b0}}});
    assign max_c    = (r_max_pct < 7'd51) ? 7'd51 : ((r_max_pct > 7'd100) ? 7'd100 : r_max_pct);
    assign min_c    = 7'd100 - max_c;
    assign max_q    = 34'({max_c, {sptc_pkg::FRAC_BITS{1'b0}}});
    assign min_q    = 34'({min_c, {sptc_pkg::FRAC_BITS{1'b0}}});
    assign band     = (r_dead_pct > 6'd49) ? 6'd49 : r_dead_pct;
    assign m_pct    = 6'(max_c - 7'd50);
    assign w_pct    = 7'({1'b0, m_pct}) - 7'({1'b0, band});
    assign w_abs    = w_pct[6] ? 6'(-w_pct) : w_pct[5:0];
    assign x_a      = r_tor - sptc_pkg::TOR50;
    assign x_b      = sptc_pkg::TOR50 - r_tor;
    assign err_sum  = 16'(r_err) + 16'(r_prev);
    assign lin_q    = r_work[63] ? -$signed(r_dvd) : $signed(r_dvd);
    assign disc     = sptc_pkg::QUAD_BB[r_sel] - r_prod;
    assign q_sat    = (r_dvd[63:48] != '0) ? 49'h1_0000_0000_0000 : {1'b0, r_dvd[47:0]};
    assign off      = 27'({band, {sptc_pkg::FRAC_BITS{1'b0}}})
                    + (w_pct[6] ? -$signed(27'(r_adj)) : $signed(27'(r_adj)));

    // divider step
    assign rem_sh = {r_rem, r_dvd[sptc_pkg::DIV_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_dvs};

    // root step
    assign sq_sh    = {r_sq_rem, r_sq_x[63:62]};
    assign sq_trial = {2'b00, r_sq_root, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;

    // unit in use by each state
    always_comb begin
        st_mul  = (r_state == sptc_pkg::S_KP_MUL) || (r_state == sptc_pkg::S_KI_MUL)
               || (r_state == sptc_pkg::S_DEN_MUL) || (r_state == sptc_pkg::S_LIN_MUL)
               || (r_state == sptc_pkg::S_DISC_MUL) || (r_state == sptc_pkg::S_ADJ_MUL);
        st_div  = (r_state == sptc_pkg::S_INT_DIV) || (r_state == sptc_pkg::S_AW_DIV)
               || (r_state == sptc_pkg::S_LIN_DIV) || (r_state == sptc_pkg::S_SOL_DIV)
               || (r_state == sptc_pkg::S_ADJ_DIV) || (r_state == sptc_pkg::S_FRAC_DIV);
        st_sqrt = (r_state == sptc_pkg::S_SQRT);
        st_op   = st_mul || st_div || st_sqrt;
        op_done = r_run && (r_cnt == '0);
        if (st_mul) begin
            op_steps = sptc_pkg::MUL_STEPS;
        end else if (st_div) begin
            op_steps = sptc_pkg::DIV_STEPS;
        end else begin
            op_steps = sptc_pkg::ROOT_STEPS;
        end
        out_free = !r_out_valid || i_ready;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sptc_pkg::S_IDLE:      if (i_valid) n_state = sptc_pkg::S_INT_DIV;
            sptc_pkg::S_INT_DIV:   if (op_done) n_state = sptc_pkg::S_KP_MUL;
            sptc_pkg::S_KP_MUL:    if (op_done) n_state = sptc_pkg::S_KI_MUL;
            sptc_pkg::S_KI_MUL:    if (op_done) n_state = sptc_pkg::S_CLAMP;
            sptc_pkg::S_CLAMP:     n_state = sptc_pkg::S_DIFF;
            sptc_pkg::S_DIFF: begin
                n_state = (r_ki != '0) ? sptc_pkg::S_DEN_MUL : sptc_pkg::S_LIN_MUL;
            end
            sptc_pkg::S_DEN_MUL:   if (op_done) n_state = sptc_pkg::S_AW_DIV;
            sptc_pkg::S_AW_DIV:    if (op_done) n_state = sptc_pkg::S_LIN_MUL;
            sptc_pkg::S_LIN_MUL:   if (op_done) n_state = sptc_pkg::S_LIN_PREP;
            sptc_pkg::S_LIN_PREP:  n_state = sptc_pkg::S_LIN_DIV;
            sptc_pkg::S_LIN_DIV: begin
                if (op_done) begin
                    n_state = (lin_q < 64'(sptc_pkg::TOR58)) ? sptc_pkg::S_LIMIT
                                                             : sptc_pkg::S_QUAD_PREP;
                end
            end
            sptc_pkg::S_QUAD_PREP: n_state = sptc_pkg::S_DISC_MUL;
            sptc_pkg::S_DISC_MUL: begin
                if (op_done) n_state = disc[63] ? sptc_pkg::S_LIMIT : sptc_pkg::S_SQRT;
            end
            sptc_pkg::S_SQRT:      if (op_done) n_state = sptc_pkg::S_SOL_DIV;
            sptc_pkg::S_SOL_DIV:   if (op_done) n_state = sptc_pkg::S_LIMIT;
            sptc_pkg::S_LIMIT:     n_state = sptc_pkg::S_MIRROR;
            sptc_pkg::S_MIRROR:    n_state = sptc_pkg::S_ADJ_MUL;
            sptc_pkg::S_ADJ_MUL:   if (op_done) n_state = sptc_pkg::S_ADJ_DIV;
            sptc_pkg::S_ADJ_DIV:   if (op_done) n_state = sptc_pkg::S_RES;
            sptc_pkg::S_RES:       n_state = sptc_pkg::S_FRAC_DIV;
            sptc_pkg::S_FRAC_DIV:  if (op_done) n_state = sptc_pkg::S_OUT;
            sptc_pkg::S_OUT:       if (out_free) n_state = sptc_pkg::S_IDLE;
            default:               n_state = sptc_pkg::S_IDLE;
        endcase
    end

    // handshake outputs and unit operands
    always_comb begin
        o_ready     = (r_state == sptc_pkg::S_IDLE);
        o_valid     = r_out_valid;
        o_cfg_ready = 1'b1;
        mul_mcand   = '0;
        mul_mplier  = '0;
        div_dvd     = '0;
        div_dvs     = '0;
        unique case (r_state)
            sptc_pkg::S_INT_DIV: begin
                div_dvd = 64'({err_sum, {sptc_pkg::ERR_SHIFT{1'b0}}});
                div_dvs = sptc_pkg::DVS_W'({rate_eff, 1'b0});
            end
            sptc_pkg::S_KP_MUL: begin
                mul_mcand  = 64'({r_err, {sptc_pkg::ERR_SHIFT{1'b0}}});
                mul_mplier = sptc_pkg::MUL_W'(r_kp);
            end
            sptc_pkg::S_KI_MUL: begin
                mul_mcand  = 64'(r_integ);
                mul_mplier = sptc_pkg::MUL_W'(r_ki);
            end
            sptc_pkg::S_DEN_MUL: begin
                mul_mcand  = 64'(rate_eff);
                mul_mplier = sptc_pkg::MUL_W'(r_ki);
            end
            sptc_pkg::S_AW_DIV: begin
                div_dvd = {r_mag[55:0], 8'b0};
                div_dvs = r_den;
            end
            sptc_pkg::S_LIN_MUL: begin
                mul_mcand  = 64'(r_u);
                mul_mplier = sptc_pkg::PCT_SCALE;
            end
            sptc_pkg::S_LIN_DIV: begin
                div_dvd = r_work[63] ? 64'(-r_work) : 64'(r_work);
                div_dvs = sptc_pkg::LIN_B[r_sel];
            end
            sptc_pkg::S_DISC_MUL: begin
                mul_mcand  = r_work;
                mul_mplier = sptc_pkg::QUAD_A4[r_sel];
            end
            sptc_pkg::S_SOL_DIV: begin
                div_dvd = {r_work[47:0], {sptc_pkg::FRAC_BITS{1'b0}}};
                div_dvs = sptc_pkg::QUAD_A2[r_sel];
            end
            sptc_pkg::S_ADJ_MUL: begin
                mul_mcand  = 64'(r_ax);
                mul_mplier = sptc_pkg::MUL_W'(w_abs);
            end
            sptc_pkg::S_ADJ_DIV: begin
                div_dvd = r_prod;
                div_dvs = sptc_pkg::DVS_W'(m_pct);
            end
            sptc_pkg::S_FRAC_DIV: begin
                div_dvd = (r_res > 27'sd0) ? 64'({r_res[25:0], {sptc_pkg::FRAC_BITS{1'b0}}})
                                           : 64'd0;
                div_dvs = sptc_pkg::FRAC_DEN;
            end
            default: begin
                mul_mcand = '0;
            end
        endcase
    end

    // control registers, configuration and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sptc_pkg::S_IDLE;
            r_run       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_kp        <= 16'd77;
            r_ki        <= 16'd128;
            r_lim       <= 16'd7000;
            r_rate      <= 10'd50;
            r_max_pct   <= 7'd63;
            r_dead_pct  <= 6'd5;
            r_integ     <= '0;
            r_prev      <= '0;
        end else begin
            r_state <= n_state;

            // iteration counter of the shared units
            if (st_op) begin
                if (!r_run) begin
                    r_run <= 1'b1;
                    r_cnt <= op_steps;
                end else if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                end else begin
                    r_run <= 1'b0;
                end
            end

            // configuration beat
            if (i_cfg_valid) begin
                unique case (sptc_pkg::t_cfg_idx'(i_cfg_index))
                    sptc_pkg::CFG_KP_GAIN:      r_kp       <= i_cfg_data;
                    sptc_pkg::CFG_KI_GAIN:      r_ki       <= i_cfg_data;
                    sptc_pkg::CFG_OUTPUT_LIMIT: r_lim      <= i_cfg_data;
                    sptc_pkg::CFG_SAMPLE_RATE:  r_rate     <= i_cfg_data[9:0];
                    sptc_pkg::CFG_MAX_TORQUE:   r_max_pct  <= i_cfg_data[6:0];
                    sptc_pkg::CFG_DEADBAND:     r_dead_pct <= i_cfg_data[5:0];
                    default:                    r_kp       <= r_kp;
                endcase
            end

            // trapezoidal integration step
            if ((r_state == sptc_pkg::S_INT_DIV) && op_done) begin
                r_integ <= sptc_pkg::sat48(50'(r_integ) + $signed(50'(r_dvd[28:0])));
                r_prev  <= r_err;
            end

            // back-calculation anti-windup
            if ((r_state == sptc_pkg::S_AW_DIV) && op_done) begin
                r_integ <= sptc_pkg::sat48(r_dneg ? 50'(r_integ) - $signed({1'b0, q_sat})
                                                  : 50'(r_integ) + $signed({1'b0, q_sat}));
            end

            // output register
            if ((r_state == sptc_pkg::S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item datapath and serial units
    always_ff @(posedge i_clk) begin
        // capture of an input beat
        if (o_ready && i_valid) begin
            r_neg <= in_diff[15];
            r_err <= in_diff[15] ? 15'(-in_diff) : in_diff[14:0];
            if (i_vehicle_speed > 12'sd360) begin
                r_sel <= 2'd3;
            end else if (i_vehicle_speed > 12'sd280) begin
                r_sel <= 2'd2;
            end else if (i_vehicle_speed > 12'sd200) begin
                r_sel <= 2'd1;
            end else begin
                r_sel <= 2'd0;
            end
        end

        // multiplier: one multiplier bit per cycle, msb first
        if (st_mul) begin
            if (!r_run) begin
                r_mcand  <= mul_mcand;
                r_mplier <= mul_mplier;
                r_prod   <= '0;
            end else if (r_cnt != '0) begin
                r_prod   <= (r_prod <<< 1) + (r_mplier[sptc_pkg::MUL_W-1] ? r_mcand : 64'sd0);
                r_mplier <= r_mplier << 1;
            end
        end

        // restoring divider: one quotient bit per cycle
        if (st_div) begin
            if (!r_run) begin
                r_dvd <= div_dvd;
                r_dvs <= div_dvs;
                r_rem <= '0;
            end else if (r_cnt != '0) begin
                r_rem <= rem_ge ? sptc_pkg::DVS_W'(rem_sh - {1'b0, r_dvs})
                                : rem_sh[sptc_pkg::DVS_W-1:0];
                r_dvd <= {r_dvd[sptc_pkg::DIV_W-2:0], rem_ge};
            end
        end

        // square root: one root bit per cycle
        if (st_sqrt) begin
            if (!r_run) begin
                r_sq_x    <= r_work;
                r_sq_rem  <= '0;
                r_sq_root <= '0;
            end else if (r_cnt != '0) begin
                r_sq_rem  <= sq_ge ? 34'(sq_sh - sq_trial) : sq_sh[33:0];
                r_sq_root <= {r_sq_root[30:0], sq_ge};
                r_sq_x    <= r_sq_x << 2;
            end
        end

        // per state captures
        unique case (r_state)
            sptc_pkg::S_KP_MUL: begin
                if (op_done) r_uu <= $signed({8'b0, r_prod[63:8]});
            end
            sptc_pkg::S_KI_MUL: begin
                if (op_done) r_uu <= r_uu + (r_prod >>> 8);
            end
            sptc_pkg::S_CLAMP: begin
                r_dneg <= r_uu > 64'(lim_q);
                r_clip <= (r_uu > 64'(lim_q)) || (r_uu < 64'(-lim_q));
                if (r_uu > 64'(lim_q)) begin
                    r_u <= lim_q;
                end else if (r_uu < 64'(-lim_q)) begin
                    r_u <= -lim_q;
                end else begin
                    r_u <= r_uu[33:0];
                end
            end
            sptc_pkg::S_DIFF: begin
                if (!r_clip) begin
                    r_mag <= '0;
                end else if (r_dneg) begin
                    r_mag <= 64'(r_uu - 64'(r_u));
                end else begin
                    r_mag <= 64'(64'(r_u) - r_uu);
                end
            end
            sptc_pkg::S_DEN_MUL: begin
                if (op_done) r_den <= r_prod[sptc_pkg::DVS_W-1:0];
            end
            sptc_pkg::S_LIN_MUL: begin
                if (op_done) r_u10k <= r_prod;
            end
            sptc_pkg::S_LIN_PREP: begin
                r_work <= r_u10k + sptc_pkg::LIN_A_SH[r_sel];
            end
            sptc_pkg::S_LIN_DIV: begin
                if (op_done) r_tor <= lin_q[33:0];
            end
            sptc_pkg::S_QUAD_PREP: begin
                r_work <= sptc_pkg::QUAD_C[r_sel] - (r_u10k >>> sptc_pkg::FRAC_BITS);
            end
            sptc_pkg::S_DISC_MUL: begin
                if (op_done) begin
                    r_work <= disc;
                    r_tor  <= sptc_pkg::TOR50;
                end
            end
            sptc_pkg::S_SQRT: begin
                if (op_done) r_work <= sptc_pkg::QUAD_NB[r_sel] + $signed({32'b0, r_sq_root});
            end
            sptc_pkg::S_SOL_DIV: begin
                if (op_done) begin
                    r_tor <= ($signed(r_dvd) > 64'(sptc_pkg::TOR58)) ? r_dvd[33:0]
                                                                     : sptc_pkg::TOR50;
                end
            end
            sptc_pkg::S_LIMIT: begin
                if (r_tor > max_q) begin
                    r_tor <= max_q;
                end else if (r_tor < min_q) begin
                    r_tor <= min_q;
                end
            end
            sptc_pkg::S_MIRROR: begin
                r_ax    <= x_a[33] ? x_b[22:0] : x_a[22:0];
                r_xzero <= (x_a == '0);
                r_xneg  <= (x_a != '0) && (x_a[33] != r_neg);
            end
            sptc_pkg::S_ADJ_DIV: begin
                if (op_done) r_adj <= r_dvd[22:0];
            end
            sptc_pkg::S_RES: begin
                if (r_xzero) begin
                    r_res <= 27'(sptc_pkg::TOR50);
                end else if (r_xneg) begin
                    r_res <= 27'(sptc_pkg::TOR50) - off;
                end else begin
                    r_res <= 27'(sptc_pkg::TOR50) + off;
                end
            end
            sptc_pkg::S_FRAC_DIV: begin
                if (op_done) r_frac <= (r_dvd[63:16] != '0) ? 16'hFFFF : r_dvd[15:0];
            end
            sptc_pkg::S_OUT: begin
                if (out_free) r_out <= r_frac;
            end
            default: begin
                r_frac <= r_frac;
            end
        endcase
    end

    assign o_torque_command = r_out;

    // sequencer checks
    a_idle_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sptc_pkg::S_IDLE) |-> !r_run)
        else $error("shared unit running while idle");

    a_cnt_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> r_run)
        else $error("iteration count left without a running unit");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == sptc_pkg::S_INT_DIV))
        else $error("accepted beat did not start integration");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == sptc_pkg::S_OUT) && out_free) |=> o_valid)
        else $error("finished result not presented");

    a_root_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == sptc_pkg::S_SQRT) && !r_run) |-> !r_work[63])
        else $error("root started on a negative discriminant");

endmodule

// ===== dv/sptc_checker.sv =====
// torque controller checker: watches the beats, predicts each torque command and compares
module sptc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic signed [14:0] i_target_angle,
    input  logic signed [14:0] i_measured_angle,
    input  logic signed [11:0] i_vehicle_speed,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic [15:0]        o_torque_command,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);

    localparam longint ONE = longint'(1) <<< sptc_pkg::FRAC_BITS;
    localparam longint I48_HI = 64'sd140737488355327;
    localparam longint I48_LO = -64'sd140737488355328;

    // speed band map coefficients, scaled by 1e4
    localparam longint MAP_LIN_A [4] = '{32962000, 21206000, 18169000, 14562000};
    localparam longint MAP_LIN_B [4] = '{659250, 424125, 363375, 291250};
    localparam longint MAP_QA [4] = '{1533038, 1286633, 758444, 593657};
    localparam longint MAP_QB [4] = '{-168217170, -145557517, -85858332, -68027173};
    localparam longint MAP_QC [4] = '{64'sd4604729340, 64'sd4117496327,
                                      64'sd2431283957, 64'sd1950844799};

    // register copies and loop state
    longint unsigned kp, ki, out_lim, rate_hz, max_pct, db_pct;
    longint          integ_acc;
    longint unsigned last_err;

    logic [15:0] torque_exp_q [$];
    int          mismatches;

    assign o_errors  = mismatches;
    assign o_pending = torque_exp_q.size();

    function automatic longint clamp_i48(longint v);
        if (v > I48_HI) begin
            return I48_HI;
        end
        if (v < I48_LO) begin
            return I48_LO;
        end
        return v;
    endfunction

    // root found one bit at a time, 32 bits deep
    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned acc;
        longint unsigned trial;
        acc = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = acc | (longint'(1) << b);
            if (trial * trial <= v) begin
                acc = trial;
            end
        end
        return acc;
    endfunction

    // one control tick: updates the integrator and returns the torque command
    function automatic logic [15:0] torque_for_tick(logic signed [14:0] tgt,
                                                    logic signed [14:0] mea,
                                                    logic signed [11:0] spd);
        longint          diff, spd_c, e_q, uu, u, lim, d, tq, tor, u4, disc, num, sol;
        longint          maxp, minp, dband, m, w, x, ax, adj, off, res, torque;
        longint unsigned e_raw, rate, mag, den, q1, r, q, frac;
        bit              neg;
        int              sel;
        diff  = longint'(tgt) - longint'(mea);
        neg   = diff < 0;
        e_raw = neg ? -diff : diff;
        rate  = (rate_hz != 0) ? rate_hz : 1;
        spd_c = (spd < 0) ? 0 : longint'(spd);

        // trapezoidal integration
        integ_acc = clamp_i48(integ_acc +
            longint'(((e_raw + (last_err & 64'hFF_FFFF)) << (sptc_pkg::FRAC_BITS - 4))
                     / (2 * rate)));
        last_err  = e_raw;

        // pi output with saturation
        e_q = longint'(e_raw << (sptc_pkg::FRAC_BITS - 4));
        uu  = longint'((kp * longint'(e_q)) >> 8) + ((longint'(ki) * integ_acc) >>> 8);
        lim = longint'(out_lim) * ONE;
        u   = (uu > lim) ? lim : ((uu < -lim) ? -lim : uu);

        // back-calculation anti-windup
        if (ki != 0) begin
            d   = u - uu;
            mag = (d < 0) ? -d : d;
            den = rate * ki;
            q1  = mag / den;
            r   = mag % den;
            if (q1 >= (64'd1 << 40)) begin
                q = 64'd1 << 48;
            end else begin
                q = q1 * 256 + (r * 256) / den;
            end
            integ_acc = clamp_i48((d < 0) ? integ_acc - longint'(q) : integ_acc + longint'(q));
        end

        // speed band
        if (spd_c > 200 && spd_c <= 280) begin
            sel = 1;
        end else if (spd_c > 280 && spd_c <= 360) begin
            sel = 2;
        end else if (spd_c > 360) begin
            sel = 3;
        end else begin
            sel = 0;
        end

        // linear map, quadratic root at 58 percent and above
        tq = (u * 10000 + MAP_LIN_A[sel] * ONE) / MAP_LIN_B[sel];
        if (tq < 58 * ONE) begin
            tor = tq;
        end else begin
            u4   = (u * 10000) >>> sptc_pkg::FRAC_BITS;
            disc = MAP_QB[sel] * MAP_QB[sel] - 4 * MAP_QA[sel] * (MAP_QC[sel] - u4);
            tor  = 50 * ONE;
            if (disc >= 0) begin
                num = -MAP_QB[sel] + longint'(int_root(disc));
                sol = (num * ONE) / (2 * MAP_QA[sel]);
                if (sol > 58 * ONE) begin
                    tor = sol;
                end
            end
        end

        // torque limits and mirroring
        maxp = longint'(max_pct);
        if (maxp < 51) begin
            maxp = 51;
        end
        if (maxp > 100) begin
            maxp = 100;
        end
        minp = 100 - maxp;
        if (tor > maxp * ONE) begin
            tor = maxp * ONE;
        end else if (tor < minp * ONE) begin
            tor = minp * ONE;
        end
        torque = neg ? 100 * ONE - tor : tor;

        // deadband compensation
        dband = (db_pct > 49) ? 49 : longint'(db_pct);
        m     = maxp - 50;
        w     = m - dband;
        x     = torque - 50 * ONE;
        if (x == 0) begin
            res = 50 * ONE;
        end else begin
            ax  = (x < 0) ? -x : x;
            adj = (ax * ((w < 0) ? -w : w)) / m;
            off = dband * ONE + ((w < 0) ? -adj : adj);
            res = (x > 0) ? 50 * ONE + off : 50 * ONE - off;
        end

        // fraction of full scale
        if (res <= 0) begin
            frac = 0;
        end else begin
            frac = (longint'(res) << 16) / longint'(100 * ONE);
            if (frac > 65535) begin
                frac = 65535;
            end
        end
        return frac[15:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    initial begin
        mismatches = 0;
    end

    // follow config, input and result beats
    always @(posedge i_clk) begin
        logic [15:0] exp_torque;
        if (!i_rst_n) begin
            kp        = 77;
            ki        = 128;
            out_lim   = 7000;
            rate_hz   = 50;
            max_pct   = 63;
            db_pct    = 5;
            integ_acc = 0;
            last_err  = 0;
            torque_exp_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    sptc_pkg::CFG_KP_GAIN:      kp      = 64'(i_cfg_data);
                    sptc_pkg::CFG_KI_GAIN:      ki      = 64'(i_cfg_data);
                    sptc_pkg::CFG_OUTPUT_LIMIT: out_lim = 64'(i_cfg_data);
                    sptc_pkg::CFG_SAMPLE_RATE:  rate_hz = 64'(i_cfg_data[9:0]);
                    sptc_pkg::CFG_MAX_TORQUE:   max_pct = 64'(i_cfg_data[6:0]);
                    sptc_pkg::CFG_DEADBAND:     db_pct  = 64'(i_cfg_data[5:0]);
                    default: ;
                endcase
            end
            if (o_valid && i_ready) begin
                if (torque_exp_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected torque beat %0d", o_torque_command));
                end else begin
                    exp_torque = torque_exp_q.pop_front();
                    if (o_torque_command !== exp_torque) begin
                        report_mismatch($sformatf("torque_command got %0d expected %0d",
                                                  o_torque_command, exp_torque));
                    end
                end
            end
            if (i_valid && o_ready) begin
                torque_exp_q.push_back(torque_for_tick(i_target_angle, i_measured_angle,
                                                       i_vehicle_speed));
            end
        end
    end

endmodule

// ===== dv/testbench.sv =====
// top of the torque controller testbench: clock, reset, stimulus and verdict
module testbench;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [14:0] i_target_angle;
    logic signed [14:0] i_measured_angle;
    logic signed [11:0] i_vehicle_speed;
    logic               o_valid;
    logic               i_ready;
    logic [15:0]        o_torque_command;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;
    int                 errors;
    int                 pending;

    bit idle_on;
    bit hold_req;

    steering_pi_torque_controller dut (.*);

    sptc_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_target_angle, .i_measured_angle,
        .i_vehicle_speed, .o_valid, .i_ready, .o_torque_command, .i_cfg_valid,
        .o_cfg_ready, .i_cfg_index, .i_cfg_data, .o_errors(errors), .o_pending(pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random stalls and one long hold-off
    initial begin
        i_ready = 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (1500) @(posedge i_clk);
                hold_req = 1'b0;
                i_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // one input beat; valid stays up unless a gap follows
    task automatic send_tick(logic signed [14:0] tgt, logic signed [14:0] mea,
                             logic signed [11:0] spd);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_target_angle   <= tgt;
        i_measured_angle <= mea;
        i_vehicle_speed  <= spd;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // register write, only with the block idle
    task automatic write_reg(sptc_pkg::t_cfg_idx idx, logic [15:0] data);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [15:0] kp, logic [15:0] ki, logic [15:0] lim,
                             logic [15:0] rate, logic [15:0] maxp, logic [15:0] db);
        write_reg(sptc_pkg::CFG_KP_GAIN, kp);
        write_reg(sptc_pkg::CFG_KI_GAIN, ki);
        write_reg(sptc_pkg::CFG_OUTPUT_LIMIT, lim);
        write_reg(sptc_pkg::CFG_SAMPLE_RATE, rate);
        write_reg(sptc_pkg::CFG_MAX_TORQUE, maxp);
        write_reg(sptc_pkg::CFG_DEADBAND, db);
    endtask

    // mostly tracking-like angles near each other, some fully random
    task automatic random_ticks(int count);
        logic signed [14:0] tgt;
        logic signed [14:0] mea;
        logic signed [11:0] spd;
        for (int n = 0; n < count; n++) begin
            tgt = 15'($urandom);
            case ($urandom_range(0, 3))
                0: mea = 15'($urandom);
                1: mea = tgt;
                default: mea = tgt + 15'($signed($urandom_range(0, 800)) - 400);
            endcase
            case ($urandom_range(0, 4))
                0: spd = 12'($urandom);
                1: spd = 12'($urandom_range(0, 200));
                2: spd = 12'($urandom_range(195, 285));
                3: spd = 12'($urandom_range(275, 365));
                default: spd = 12'($urandom_range(355, 2047));
            endcase
            send_tick(tgt, mea, spd);
        end
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_target_angle   = '0;
        i_measured_angle = '0;
        i_vehicle_speed  = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = sptc_pkg::CFG_KP_GAIN;
        i_cfg_data       = '0;
        idle_on          = 1'b1;
        hold_req         = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero error, angle extremes, every speed band edge
        send_tick(15'sd0, 15'sd0, 12'sd0);
        send_tick(15'sd16383, -15'sd16384, 12'sd100);
        send_tick(-15'sd16384, 15'sd16383, 12'sd100);
        send_tick(15'sd16383, -15'sd16384, -12'sd2048);
        send_tick(15'sd100, 15'sd99, 12'sd200);
        send_tick(15'sd5000, 15'sd0, 12'sd201);
        send_tick(-15'sd5000, 15'sd0, 12'sd280);
        send_tick(15'sd9000, -15'sd9000, 12'sd281);
        send_tick(15'sd300, 15'sd300, 12'sd360);
        send_tick(15'sd12000, -15'sd4000, 12'sd361);
        send_tick(-15'sd16384, -15'sd16384, 12'sd2047);
        send_tick(15'sd1, 15'sd0, 12'sd2047);

        // register extremes and out-of-range values, indexes beyond the list
        write_all(16'd65535, 16'd0, 16'd65535, 16'd0, 16'd127, 16'd63);
        write_reg(sptc_pkg::t_cfg_idx'(3'd6), 16'hFFFF);
        write_reg(sptc_pkg::t_cfg_idx'(3'd7), 16'h0000);
        send_tick(15'sd16383, -15'sd16384, 12'sd0);
        send_tick(-15'sd16384, 15'sd16383, 12'sd400);
        send_tick(15'sd20, 15'sd0, 12'sd250);
        write_all(16'd0, 16'd65535, 16'd0, 16'd1023, 16'd0, 16'd49);
        send_tick(15'sd16383, -15'sd16384, 12'sd300);
        send_tick(15'sd40, 15'sd0, 12'sd10);
        write_all(16'd1, 16'd65535, 16'd65535, 16'd1, 16'd100, 16'd0);
        send_tick(15'sd16383, -15'sd16384, 12'sd0);
        send_tick(-15'sd16384, 15'sd16383, 12'sd500);
        send_tick(15'sd0, 15'sd0, 12'sd220);
        write_all(16'd77, 16'd128, 16'd7000, 16'd1000, 16'd51, 16'd0);
        send_tick(15'sd7000, -15'sd7000, 12'sd150);

        // random phases, each with its own settings
        hold_req = 1'b1;
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7) begin
                idle_on = 1'b0;
            end
            write_all(16'($urandom_range(0, 600)), 16'($urandom_range(0, 400)),
                      16'($urandom), 16'($urandom_range(0, 1023)),
                      16'($urandom_range(40, 127)), 16'($urandom_range(0, 63)));
            random_ticks(125);
        end

        // drain the last beat before the verdict
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("steering_pi_torque_controller regression: pass");
        end else begin
            $display("steering_pi_torque_controller regression: fail");
        end
        $finish;
    end

    // run limit
    initial begin
        #40000000;
        $display("steering_pi_torque_controller regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sptc_pkg.sv
sv/steering_pi_torque_controller.sv
dv/sptc_checker.sv
dv/testbench.sv
